[hdl/lidar_scan_stream_parser_defines.svh]
// ----------------------------------------------------------------------------
// lidar scan stream parser assertion macros
// shared concurrent assertion helpers for the parser rtl
// ----------------------------------------------------------------------------
`ifndef LIDAR_SCAN_STREAM_PARSER_DEFINES_SVH
`define LIDAR_SCAN_STREAM_PARSER_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define LSSP_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error("lssp assertion failed");

// next-cycle implication, disabled while in reset
`define LSSP_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error("lssp assertion failed");

`endif

[hdl/lssp_pkg.sv]
// ----------------------------------------------------------------------------
// lssp_pkg
// shared types and constants of the lidar scan stream parser
// ----------------------------------------------------------------------------
package lssp_pkg;

  localparam logic [7:0]  SYNC_FIRST     = 8'hA5;
  localparam logic [7:0]  SYNC_SECOND    = 8'h5A;
  localparam logic [14:0] ANGLE_LIMIT_Q6 = 15'd23040;  // 360 degrees in q6
  localparam logic [14:0] NEAREST_NONE   = 15'd16384;
  localparam logic [13:0] MIN_RANGE_RST  = 14'd50;
  localparam logic [13:0] MAX_RANGE_RST  = 14'd12000;

  // register indexes of the configuration port
  localparam logic REG_MIN_RANGE = 1'b0;
  localparam logic REG_MAX_RANGE = 1'b1;

  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_DESC   = 3'd1,
    EV_BADHDR = 3'd2,
    EV_ZEROQ  = 3'd3,
    EV_RANGE  = 3'd4,
    EV_VALID  = 3'd5
  } event_t;

  // framer to node evaluator
  typedef struct packed {
    logic       desc_done;
    logic       node_ready;
    logic       hdr_good;
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic [7:0] byte3;
    logic [7:0] byte4;
  } frame_t;

  // latched descriptor values
  typedef struct packed {
    logic        seen;
    logic [7:0]  resp_type;
    logic [29:0] length;
    logic [1:0]  mode;
  } desc_t;

  // running statistics
  typedef struct packed {
    logic [14:0] nearest;
    logic [31:0] valid_count;
    logic [31:0] start_count;
  } stats_t;

  // per-item result fields
  typedef struct packed {
    event_t      ev;
    logic        start_bit;
    logic [5:0]  quality;
    logic [11:0] angle;
    logic [13:0] node_mm;
  } result_t;

endpackage

[hdl/lssp_in_if.sv]
// ----------------------------------------------------------------------------
// lssp_in_if
// byte input channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface lssp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

[hdl/lssp_out_if.sv]
// ----------------------------------------------------------------------------
// lssp_out_if
// result channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface lssp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_res;
  logic        desc_locked;
  logic [7:0]  resp_type;
  logic [29:0] payload_length;
  logic [1:0]  resp_mode;
  logic        start_bit;
  logic [5:0]  quality;
  logic [11:0] angle_tenths;
  logic [13:0] node_mm;
  logic [14:0] nearest_mm;
  logic [31:0] valid_count;
  logic [31:0] start_total;

  modport source (
    output valid, event_res, desc_locked, resp_type, payload_length, resp_mode,
    output start_bit, quality, angle_tenths, node_mm, nearest_mm,
    output valid_count, start_total,
    input  ready
  );
  modport sink (
    input  valid, event_res, desc_locked, resp_type, payload_length, resp_mode,
    input  start_bit, quality, angle_tenths, node_mm, nearest_mm,
    input  valid_count, start_total,
    output ready
  );
endinterface

[hdl/lssp_framer.sv]
// ----------------------------------------------------------------------------
// lssp_framer
// sync hunt, descriptor capture and 5-byte node windowing
// ----------------------------------------------------------------------------
module lssp_framer (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            accept,
  input  logic [7:0]      rx_byte,
  output lssp_pkg::frame_t frame,
  output lssp_pkg::desc_t  desc
);
  import lssp_pkg::*;

  typedef enum logic [1:0] {
    PH_FIRST   = 2'd0,
    PH_SECOND  = 2'd1,
    PH_COLLECT = 2'd2
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [2:0]  didx_r, didx_nxt;
  logic [7:0]  dbyte_r [4];   // descriptor bytes 2..5
  logic [7:0]  dbyte_nxt [4];
  logic [7:0]  win_r [4];     // first four bytes of the node candidate
  logic [7:0]  win_nxt [4];
  logic [2:0]  fill_r, fill_nxt;
  desc_t       desc_r, desc_nxt;
  logic [2:0]  idx_eff;
  logic [2:0]  idx_off;
  logic        hdr_good;

  assign hdr_good = (win_r[0][0] ^ win_r[0][1]) & win_r[1][0];

  always_comb begin
    phase_nxt = phase_r;
    didx_nxt  = didx_r;
    dbyte_nxt = dbyte_r;
    win_nxt   = win_r;
    fill_nxt  = fill_r;
    desc_nxt  = desc_r;
    idx_eff   = (didx_r < 3'd2 || didx_r == 3'd7) ? 3'd2 : didx_r;
    idx_off   = idx_eff - 3'd2;

    frame.desc_done  = 1'b0;
    frame.node_ready = 1'b0;
    frame.hdr_good   = hdr_good;
    frame.byte0      = win_r[0];
    frame.byte1      = win_r[1];
    frame.byte2      = win_r[2];
    frame.byte3      = win_r[3];
    frame.byte4      = rx_byte;

    if (accept) begin
      if (!desc_r.seen) begin
        unique case (phase_r)
          PH_SECOND: begin
            if (rx_byte == SYNC_SECOND) begin
              didx_nxt  = 3'd2;
              phase_nxt = PH_COLLECT;
            end else if (rx_byte == SYNC_FIRST) begin
              didx_nxt = 3'd1;
            end else begin
              didx_nxt  = 3'd0;
              phase_nxt = PH_FIRST;
            end
          end
          PH_COLLECT: begin
            if (idx_eff == 3'd6) begin
              desc_nxt.seen      = 1'b1;
              desc_nxt.resp_type = rx_byte;
              desc_nxt.length    = {dbyte_r[3][5:0], dbyte_r[2], dbyte_r[1], dbyte_r[0]};
              desc_nxt.mode      = dbyte_r[3][7:6];
              fill_nxt           = 3'd0;
              phase_nxt          = PH_FIRST;
              didx_nxt           = 3'd0;
              frame.desc_done    = 1'b1;
            end else begin
              dbyte_nxt[idx_off[1:0]] = rx_byte;
              didx_nxt                = idx_eff + 3'd1;
            end
          end
          default: begin
            phase_nxt = PH_FIRST;
            if (rx_byte == SYNC_FIRST) begin
              didx_nxt  = 3'd1;
              phase_nxt = PH_SECOND;
            end
          end
        endcase
      end else if (fill_r >= 3'd4) begin
        frame.node_ready = 1'b1;
        if (hdr_good) begin
          fill_nxt = 3'd0;
        end else begin
          // slide by one byte, new byte completes the next candidate
          win_nxt[0] = win_r[1];
          win_nxt[1] = win_r[2];
          win_nxt[2] = win_r[3];
          win_nxt[3] = rx_byte;
          fill_nxt   = 3'd4;
        end
      end else begin
        win_nxt[fill_r[1:0]] = rx_byte;
        fill_nxt             = fill_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FIRST;
      didx_r  <= 3'd0;
      fill_r  <= 3'd0;
      desc_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      didx_r  <= didx_nxt;
      fill_r  <= fill_nxt;
      desc_r  <= desc_nxt;
    end
    dbyte_r <= dbyte_nxt;
    win_r   <= win_nxt;
  end

  assign desc = desc_r;

endmodule

[hdl/lssp_node_eval.sv]
// ----------------------------------------------------------------------------
// lssp_node_eval
// node classification, angle scaling and running statistics
// ----------------------------------------------------------------------------
module lssp_node_eval (
  input  logic              clk,
  input  logic              rst_n,
  input  lssp_pkg::frame_t  frame,
  input  logic [13:0]       min_range,
  input  logic [13:0]       max_range,
  output lssp_pkg::result_t res,
  output lssp_pkg::stats_t  stats
);
  import lssp_pkg::*;

  stats_t      stats_r, stats_nxt;
  logic [14:0] q6;
  logic [15:0] q2;
  logic [5:0]  qual;
  logic        sflag;
  logic        out_of_range;
  logic [18:0] ang_sum;

  assign q6    = {frame.byte2, frame.byte1[7:1]};
  assign q2    = {frame.byte4, frame.byte3};
  assign qual  = frame.byte0[7:2];
  assign sflag = frame.byte0[0];

  assign out_of_range = (q6 >= ANGLE_LIMIT_Q6) || (q2 < {min_range, 2'b00}) ||
                        (q2 > {max_range, 2'b00});

  // q6 * 10 plus half an lsb of the final /64
  assign ang_sum = {1'b0, q6, 3'b000} + {3'b000, q6, 1'b0} + 19'd32;

  always_comb begin
    res       = '0;
    res.ev    = EV_NONE;
    stats_nxt = stats_r;
    if (frame.desc_done) begin
      res.ev = EV_DESC;
    end else if (frame.node_ready) begin
      if (!frame.hdr_good) begin
        res.ev = EV_BADHDR;
      end else begin
        res.start_bit = sflag;
        res.quality   = qual;
        if (sflag) begin
          stats_nxt.start_count = stats_r.start_count + 32'd1;
        end
        priority if (qual == 6'd0) begin
          res.ev = EV_ZEROQ;
        end else if (out_of_range) begin
          res.ev      = EV_RANGE;
          res.node_mm = q2[15:2];
        end else begin
          res.ev                = EV_VALID;
          res.node_mm           = q2[15:2];
          res.angle             = ang_sum[17:6];
          stats_nxt.valid_count = stats_r.valid_count + 32'd1;
          if ({1'b0, q2[15:2]} < stats_r.nearest) begin
            stats_nxt.nearest = {1'b0, q2[15:2]};
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stats_r.nearest     <= NEAREST_NONE;
      stats_r.valid_count <= 32'd0;
      stats_r.start_count <= 32'd0;
    end else begin
      stats_r <= stats_nxt;
    end
  end

  assign stats = stats_r;

endmodule

[hdl/lidar_scan_stream_parser.sv]
// ----------------------------------------------------------------------------
// lidar_scan_stream_parser
// result valid is registered: it rises in the cycle after byte accept (result register)
// throughput: one byte per cycle while the result side keeps taking items
// reset: synchronous active-low rst_n; hunt restarts, counters clear,
// nearest reads 16384, range limits return to 50 and 12000 mm
// ----------------------------------------------------------------------------
`include "lidar_scan_stream_parser_defines.svh"

module lidar_scan_stream_parser (
  input  logic        clk,
  input  logic        rst_n,
  lssp_in_if.sink     in_bus,
  lssp_out_if.source  out_bus,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import lssp_pkg::*;

  // apb registers
  logic [13:0] min_range_r;
  logic [13:0] max_range_r;
  logic        cfg_wr;

  // datapath
  logic    in_accept;
  frame_t  frame;
  desc_t   desc;
  result_t res;
  stats_t  stats;

  // result register
  result_t res_r;
  logic    out_valid_r;

  // ---------------------------------------------------------------------------
  // configuration port, one register per word, decoded on paddr[2]
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_range_r <= MIN_RANGE_RST;
      max_range_r <= MAX_RANGE_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_MIN_RANGE) begin
        min_range_r <= pwdata[13:0];
      end else begin
        max_range_r <= pwdata[13:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_MAX_RANGE) ? {18'd0, max_range_r} : {18'd0, min_range_r};

  // ---------------------------------------------------------------------------
  // handshake: take a new item whenever the result slot is empty or draining
  // ---------------------------------------------------------------------------
  assign in_bus.ready = !out_valid_r || out_bus.ready;
  assign in_accept    = in_bus.valid && in_bus.ready;

  // sync hunt, descriptor capture, node window
  lssp_framer u_framer (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (in_accept),
    .rx_byte (in_bus.rx_byte),
    .frame   (frame),
    .desc    (desc)
  );

  // header, quality, range checks and statistics
  lssp_node_eval u_eval (
    .clk       (clk),
    .rst_n     (rst_n),
    .frame     (frame),
    .min_range (min_range_r),
    .max_range (max_range_r),
    .res       (res),
    .stats     (stats)
  );

  // ---------------------------------------------------------------------------
  // result register; per-item fields are captured, while descriptor and
  // statistics are read live (state only moves on accept, and no accept
  // happens while a result sits stalled)
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
    if (in_accept) begin
      res_r <= res;
    end
  end

  assign out_bus.valid          = out_valid_r;
  assign out_bus.event_res      = res_r.ev;
  assign out_bus.desc_locked    = desc.seen;
  assign out_bus.resp_type      = desc.resp_type;
  assign out_bus.payload_length = desc.length;
  assign out_bus.resp_mode      = desc.mode;
  assign out_bus.start_bit      = res_r.start_bit;
  assign out_bus.quality        = res_r.quality;
  assign out_bus.angle_tenths   = res_r.angle;
  assign out_bus.node_mm        = res_r.node_mm;
  assign out_bus.nearest_mm     = stats.nearest;
  assign out_bus.valid_count    = stats.valid_count;
  assign out_bus.start_total    = stats.start_count;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // every accepted byte yields a result in the next cycle
  `LSSP_ASSERT_NEXT(a_accept_gives_result, clk, rst_n, in_accept, out_bus.valid)
  // no node events before the descriptor has been received
  `LSSP_ASSERT_IMPL(a_no_node_before_desc, clk, rst_n,
    out_bus.valid && !out_bus.desc_locked, out_bus.event_res == EV_NONE)
  // a valid node never leaves the minimum above its own distance
  `LSSP_ASSERT_IMPL(a_nearest_tracks, clk, rst_n,
    out_bus.valid && out_bus.event_res == EV_VALID,
    out_bus.nearest_mm <= {1'b0, out_bus.node_mm})

endmodule

[sim/lssp_scan_checker.sv]
// ----------------------------------------------------------------------------
// lssp_scan_checker
// watches the byte and result channels of the scan stream parser, predicts
// every result from the accepted bytes and the range writes, and compares
// ----------------------------------------------------------------------------
module lssp_scan_checker (
  input  logic        clk,
  input  logic        rst_n,
  lssp_in_if          in_mon,
  lssp_out_if         out_mon,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output int unsigned fail_count,
  output int unsigned pending_results
);
  timeunit 1ns;
  timeprecision 1ps;

  import lssp_pkg::*;

  typedef enum logic [1:0] {
    HUNT_FIRST   = 2'd0,
    HUNT_SECOND  = 2'd1,
    HUNT_COLLECT = 2'd2
  } hunt_phase_t;

  typedef struct packed {
    event_t      ev;
    logic        seen;
    logic [7:0]  resp_type;
    logic [29:0] length;
    logic [1:0]  mode;
    logic        start_bit;
    logic [5:0]  quality;
    logic [11:0] angle;
    logic [13:0] node_mm;
    logic [14:0] nearest;
    logic [31:0] valid_count;
    logic [31:0] start_count;
  } scan_result_t;

  // parser state
  hunt_phase_t  phase;
  logic [2:0]   desc_idx;
  logic [7:0]   desc_bytes [7];
  logic         seen;
  logic [7:0]   win [5];
  logic [2:0]   fill;
  logic [7:0]   type_q;
  logic [29:0]  len_q;
  logic [1:0]   mode_q;
  logic [14:0]  nearest_q;
  logic [31:0]  valid_cnt;
  logic [31:0]  start_cnt;
  logic [13:0]  min_mm;
  logic [13:0]  max_mm;

  scan_result_t expected_results [$];
  int unsigned  failures;
  int unsigned  results_seen;

  task automatic clear_parser();
    int i;
    phase     = HUNT_FIRST;
    desc_idx  = '0;
    for (i = 0; i < 7; i++) desc_bytes[i] = '0;
    for (i = 0; i < 5; i++) win[i] = '0;
    seen      = 1'b0;
    fill      = '0;
    type_q    = '0;
    len_q     = '0;
    mode_q    = '0;
    nearest_q = NEAREST_NONE;
    valid_cnt = '0;
    start_cnt = '0;
    min_mm    = MIN_RANGE_RST;
    max_mm    = MAX_RANGE_RST;
  endtask

  task automatic predict_scan_result(input logic [7:0] b, output scan_result_t r);
    logic [14:0] q6;
    logic [15:0] q2;
    int unsigned ang;
    int          i;
    r    = '0;
    r.ev = EV_NONE;
    if (!seen) begin
      case (phase)
        HUNT_SECOND: begin
          if (b == SYNC_SECOND) begin
            desc_bytes[1] = b;
            desc_idx      = 3'd2;
            phase         = HUNT_COLLECT;
          end else if (b == SYNC_FIRST) begin
            desc_bytes[0] = b;
            desc_idx      = 3'd1;
          end else begin
            phase    = HUNT_FIRST;
            desc_idx = 3'd0;
          end
        end
        HUNT_COLLECT: begin
          desc_bytes[desc_idx] = b;
          if (desc_idx == 3'd6) begin
            type_q   = desc_bytes[6];
            len_q    = {desc_bytes[5][5:0], desc_bytes[4], desc_bytes[3], desc_bytes[2]};
            mode_q   = desc_bytes[5][7:6];
            seen     = 1'b1;
            fill     = 3'd0;
            phase    = HUNT_FIRST;
            desc_idx = 3'd0;
            r.ev     = EV_DESC;
          end else begin
            desc_idx = desc_idx + 3'd1;
          end
        end
        default: begin
          phase = HUNT_FIRST;
          if (b == SYNC_FIRST) begin
            desc_bytes[0] = b;
            desc_idx      = 3'd1;
            phase         = HUNT_SECOND;
          end
        end
      endcase
    end else begin
      win[fill] = b;
      if (fill < 3'd4) begin
        fill = fill + 3'd1;
      end else begin
        q6 = {win[2], win[1][7:1]};
        q2 = {win[4], win[3]};
        if ((win[0][0] == win[0][1]) || !win[1][0]) begin
          // bad header: slide by one byte
          for (i = 0; i < 4; i++) win[i] = win[i+1];
          fill = 3'd4;
          r.ev = EV_BADHDR;
        end else begin
          r.start_bit = win[0][0];
          r.quality   = win[0][7:2];
          fill        = 3'd0;
          if (win[0][0]) start_cnt = start_cnt + 32'd1;
          if (r.quality == 6'd0) begin
            r.ev = EV_ZEROQ;
          end else if (q6 >= ANGLE_LIMIT_Q6 || q2 < {min_mm, 2'b00} || q2 > {max_mm, 2'b00}) begin
            r.ev      = EV_RANGE;
            r.node_mm = q2[15:2];
          end else begin
            r.ev      = EV_VALID;
            r.node_mm = q2[15:2];
            ang       = (int'(q6) * 10 + 32) >> 6;
            r.angle   = ang[11:0];
            valid_cnt = valid_cnt + 32'd1;
            if ({1'b0, r.node_mm} < nearest_q) nearest_q = {1'b0, r.node_mm};
          end
        end
      end
    end
    r.seen        = seen;
    r.resp_type   = type_q;
    r.length      = len_q;
    r.mode        = mode_q;
    r.nearest     = nearest_q;
    r.valid_count = valid_cnt;
    r.start_count = start_cnt;
  endtask

  function automatic bit field_differs(string name, logic [31:0] want, logic [31:0] got);
    if (want === got) return 1'b0;
    if (failures < 10) begin
      $display("checker: result %0d %s expected 0x%0h got 0x%0h",
               results_seen, name, want, got);
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    scan_result_t want_r;
    scan_result_t got_r;
    bit           bad;
    if (!rst_n) begin
      clear_parser();
      expected_results.delete();
      failures     = 0;
      results_seen = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got_r.ev          = event_t'(out_mon.event_res);
        got_r.seen        = out_mon.desc_locked;
        got_r.resp_type   = out_mon.resp_type;
        got_r.length      = out_mon.payload_length;
        got_r.mode        = out_mon.resp_mode;
        got_r.start_bit   = out_mon.start_bit;
        got_r.quality     = out_mon.quality;
        got_r.angle       = out_mon.angle_tenths;
        got_r.node_mm     = out_mon.node_mm;
        got_r.nearest     = out_mon.nearest_mm;
        got_r.valid_count = out_mon.valid_count;
        got_r.start_count = out_mon.start_total;
        if (expected_results.size() == 0) begin
          if (failures < 10) begin
            $display("checker: result %0d arrived with nothing expected", results_seen);
          end
          failures++;
        end else begin
          want_r = expected_results.pop_front();
          bad = field_differs("event_res", 32'(want_r.ev), 32'(got_r.ev));
          bad |= field_differs("desc_locked", 32'(want_r.seen), 32'(got_r.seen));
          bad |= field_differs("resp_type", 32'(want_r.resp_type), 32'(got_r.resp_type));
          bad |= field_differs("payload_length", 32'(want_r.length), 32'(got_r.length));
          bad |= field_differs("resp_mode", 32'(want_r.mode), 32'(got_r.mode));
          bad |= field_differs("start_bit", 32'(want_r.start_bit), 32'(got_r.start_bit));
          bad |= field_differs("quality", 32'(want_r.quality), 32'(got_r.quality));
          bad |= field_differs("angle_tenths", 32'(want_r.angle), 32'(got_r.angle));
          bad |= field_differs("node_mm", 32'(want_r.node_mm), 32'(got_r.node_mm));
          bad |= field_differs("nearest_mm", 32'(want_r.nearest), 32'(got_r.nearest));
          bad |= field_differs("valid_count", want_r.valid_count, got_r.valid_count);
          bad |= field_differs("start_total", want_r.start_count, got_r.start_count);
          if (bad) failures++;
        end
        results_seen++;
      end
      if (in_mon.valid && in_mon.ready) begin
        predict_scan_result(in_mon.rx_byte, want_r);
        expected_results.push_back(want_r);
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_MIN_RANGE) min_mm = pwdata[13:0];
        else max_mm = pwdata[13:0];
      end
    end
    fail_count      <= failures;
    pending_results <= expected_results.size();
  end

endmodule

[sim/tb_lidar_scan_stream_parser.sv]
// ----------------------------------------------------------------------------
// tb_lidar_scan_stream_parser
// drives the scan stream parser with a descriptor hunt, framed scan nodes
// and noise under several range settings, with random idling on both sides
// ----------------------------------------------------------------------------
module tb_lidar_scan_stream_parser;
  timeunit 1ns;
  timeprecision 1ps;

  import lssp_pkg::*;

  localparam int unsigned IDLE_LIMIT   = 4000;  // cycles with no handshake at all
  localparam int unsigned LONG_HOLD    = 400;   // receiver hold-off, fills the block
  localparam int unsigned PHASE_BYTES  = 140;

  // hunt noise, sync pair and descriptor payload:
  // stray byte, repeated first sync byte, broken pair with a 5a that must not
  // count, then a clean pair and length 0x3fff00ff, mode 3, type 81
  localparam logic [7:0] HUNT_BYTES [12] = '{
    8'h00, 8'hA5, 8'hA5, 8'h5B, 8'h5A, 8'hA5, 8'h5A,
    8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h81
  };

  logic        clk = 1'b0;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  lssp_in_if  byte_bus ();
  lssp_out_if result_bus ();

  int unsigned fail_count;
  int unsigned pending_results;
  int unsigned bytes_sent;
  int unsigned idle_cycles;
  int unsigned hold_off_reqs;  // count of long hold-offs asked of the receiver
  bit          steady_stream;  // sender stretch with no gaps
  bit          ready_state;
  logic [13:0] cur_min;        // range limits as last written, shapes distances
  logic [13:0] cur_max;

  always #4 clk = ~clk;

  lidar_scan_stream_parser dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (byte_bus),
    .out_bus (result_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  lssp_scan_checker scan_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (byte_bus),
    .out_mon         (result_bus),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .pready          (pready),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  // mostly no gap, often a short one, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // byte 0 first: header, angle with check bit, distance
  function automatic logic [39:0] make_node(bit s, logic [5:0] q, logic [14:0] q6,
                                            logic [15:0] q2);
    return {q2, q6, 1'b1, q, ~s, s};
  endfunction

  // offer one item and hold it until it is taken; returns at the accepting edge
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = steady_stream ? 0 : pick_gap();
    if (gap != 0) begin
      byte_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_bus.valid   <= 1'b1;
    byte_bus.rx_byte <= b;
    do @(posedge clk); while (!byte_bus.ready);
    bytes_sent++;
  endtask

  task automatic send_node(input logic [39:0] node);
    int i;
    for (i = 0; i < 5; i++) send_byte(node[8*i +: 8]);
  endtask

  // two-phase register write, then psel and penable drop so writes never overlap
  task automatic write_reg(input logic reg_idx, input logic [13:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= {18'($urandom()), value};  // upper bits are junk, must be ignored
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // stop offering and wait for every expected result to come out
  task automatic drain_results();
    byte_bus.valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_limits(input logic [13:0] min_v, input logic [13:0] max_v);
    drain_results();
    write_reg(REG_MIN_RANGE, min_v);
    write_reg(REG_MAX_RANGE, max_v);
    cur_min = min_v;
    cur_max = max_v;
  endtask

  // one well-formed node with random content, a broken header, or junk bytes
  task automatic send_random_item();
    logic [39:0] node;
    logic [5:0]  q;
    logic [14:0] q6;
    logic [15:0] q2;
    bit          s;
    int unsigned pick;
    int unsigned lo;
    int unsigned hi;
    int unsigned n_noise;
    s    = $urandom_range(0, 1);
    pick = $urandom_range(0, 99);
    if (pick < 10) q = 6'd0;
    else if (pick < 15) q = 6'd63;
    else q = 6'($urandom_range(1, 63));
    // angle: mostly legal, some past 360 degrees, some right at the edges
    pick = $urandom_range(0, 99);
    if (pick < 80) begin
      q6 = 15'($urandom_range(0, 23039));
    end else if (pick < 88) begin
      q6 = 15'($urandom_range(23040, 32767));
    end else begin
      case ($urandom_range(0, 3))
        0:       q6 = 15'd0;
        1:       q6 = 15'd23039;
        2:       q6 = 15'd23040;
        default: q6 = 15'h7FFF;
      endcase
    end
    // distance: mostly inside the limits, some on the limits, some anywhere
    lo   = int'(cur_min) * 4;
    hi   = int'(cur_max) * 4;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      q2 = 16'($urandom_range(lo, hi));
    end else if (pick < 80) begin
      case ($urandom_range(0, 3))
        0:       q2 = (lo == 0) ? 16'd0 : 16'(lo - 1);
        1:       q2 = 16'(lo);
        2:       q2 = 16'(hi);
        default: q2 = (hi >= 65535) ? 16'hFFFF : 16'(hi + 1);
      endcase
    end else begin
      q2 = 16'($urandom_range(0, 65535));
    end
    node = make_node(s, q, q6, q2);
    pick = $urandom_range(0, 99);
    if (pick < 84) begin
      send_node(node);
    end else if (pick < 92) begin
      // start bit equal to its inverse, or check bit cleared
      if ($urandom_range(0, 1) == 1) node[1] = node[0];
      else node[8] = 1'b0;
      send_node(node);
    end else begin
      n_noise = $urandom_range(1, 3);
      repeat (n_noise) send_byte(8'($urandom()));
    end
  endtask

  task automatic random_phase(input int unsigned n_bytes);
    int unsigned target;
    target = bytes_sent + n_bytes;
    while (bytes_sent < target) begin
      if ($urandom_range(0, 7) == 0) steady_stream = ($urandom_range(0, 2) == 0);
      send_random_item();
    end
    steady_stream = 1'b0;
  endtask

  // receiver: ready runs with random gaps, long unbroken runs now and then,
  // and a long hold-off as soon as the sender asks for one
  task automatic set_ready(input bit v);
    if (ready_state != v) begin
      result_bus.ready <= v;
      ready_state = v;
    end
  endtask

  initial begin
    int unsigned run_len;
    int unsigned gap;
    int unsigned holds_done;
    int unsigned k;
    result_bus.ready <= 1'b0;
    ready_state = 1'b0;
    holds_done  = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off_reqs != holds_done) begin
        holds_done = hold_off_reqs;
        set_ready(1'b0);
        repeat (LONG_HOLD) @(posedge clk);
      end
      run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 24);
      set_ready(1'b1);
      for (k = 0; k < run_len && hold_off_reqs == holds_done; k++) @(posedge clk);
      gap = pick_gap();
      if (gap != 0 && hold_off_reqs == holds_done) begin
        set_ready(1'b0);
        for (k = 0; k < gap && hold_off_reqs == holds_done; k++) @(posedge clk);
      end
    end
  end

  // watchdog: any handshake on any port counts as progress
  always @(posedge clk) begin
    if (!rst_n || (byte_bus.valid && byte_bus.ready) ||
        (result_bus.valid && result_bus.ready) || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // stimulus and verdict
  initial begin
    int i;
    rst_n            <= 1'b0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    byte_bus.valid   <= 1'b0;
    byte_bus.rx_byte <= '0;
    bytes_sent    = 0;
    hold_off_reqs = 0;
    steady_stream = 1'b0;
    cur_min       = MIN_RANGE_RST;
    cur_max       = MAX_RANGE_RST;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // descriptor hunt with its corner cases, then the descriptor itself
    for (i = 0; i < 12; i++) send_byte(HUNT_BYTES[i]);
    // valid node with start bit, full quality, top angle, distance on max
    send_node(make_node(1'b1, 6'd63, 15'd23039, 16'd48000));
    // a byte with a bad header, then a zero-quality node carrying a5 5a as data
    send_byte(8'h00);
    send_node(make_node(1'b0, 6'd0, {8'h5A, 7'h52}, 16'hFFFF));
    // angle at exactly 360 degrees
    send_node(make_node(1'b1, 6'd1, ANGLE_LIMIT_Q6, 16'd200));

    // reset limits: open with the sender pushing while the receiver holds off
    steady_stream = 1'b1;
    hold_off_reqs++;
    random_phase(PHASE_BYTES);

    set_limits(14'd0, 14'd16383);      // widest window
    random_phase(PHASE_BYTES);
    set_limits(14'd16383, 14'd16383);  // only the top distance
    random_phase(PHASE_BYTES);
    set_limits(14'd0, 14'd0);          // only zero distance
    random_phase(PHASE_BYTES);
    set_limits(14'd9000, 14'd100);     // crossed limits, all rejected
    steady_stream = 1'b1;
    hold_off_reqs++;
    random_phase(PHASE_BYTES);
    set_limits(14'($urandom_range(0, 8000)), 14'($urandom_range(8000, 16383)));
    random_phase(PHASE_BYTES);
    set_limits(14'($urandom()), 14'($urandom()));
    random_phase(PHASE_BYTES);
    set_limits(MIN_RANGE_RST, MAX_RANGE_RST);
    random_phase(PHASE_BYTES);

    // drain, then wait for anything late before the verdict
    byte_bus.valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
